// ===== rtl/core/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Types and constants shared by the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int QBITS = 17;
    localparam int VW    = 34;
    localparam int RW    = 50;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } cau_op_t;

    typedef struct packed {
        cau_op_t                op;
        logic                   dz;
        logic signed [VW-1:0]   v_re;
        logic signed [VW-1:0]   v_im;
        logic [RW-1:0]          dsh;
        logic [RW-1:0]          rem_re;
        logic [RW-1:0]          rem_im;
        logic [QBITS-1:0]       q_re;
        logic [QBITS-1:0]       q_im;
        logic                   neg_re;
        logic                   neg_im;
        logic                   big_re;
        logic                   big_im;
    } cau_lane_t;

endpackage

// ===== rtl/core/cau_ifs.sv =====
// ----------------------------------------------------------------------------
// cau_ifs
// Operand and result channels of the complex arithmetic unit.
// ----------------------------------------------------------------------------
interface cau_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic signed [15:0] a_re;
    logic signed [15:0] a_im;
    logic signed [15:0] b_re;
    logic signed [15:0] b_im;

    modport source (output valid, opcode, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, opcode, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] r_re;
    logic signed [15:0] r_im;
    logic              div_by_zero;
    logic              overflow;

    modport source (output valid, r_re, r_im, div_by_zero, overflow, input ready);
    modport sink   (input valid, r_re, r_im, div_by_zero, overflow, output ready);
endinterface

// ===== rtl/core/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Q8.8 complex add, subtract, multiply and divide with saturation.
// ----------------------------------------------------------------------------
// Operands enter on req (opcode, a_re, a_im, b_re, b_im); one result per
// transaction leaves on rsp (r_re, r_im, div_by_zero, overflow), in order.
// Every opcode takes the same path: three front stages (products, sums,
// divider setup), a chain of 17 divide cells that each resolve one quotient
// bit per result part, and the result register. Throughput is one transaction
// per cycle unless rsp stalls; each stage has its own valid and moves
// forward whenever the stage after it is empty or moving, so bubbles close
// up while rsp is stalled. A stall on rsp fills the pipeline and then drops
// req.ready. Reset empties all stages; no state survives an item.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
    input  logic     clk,
    input  logic     rst_n,
    cau_req_if.sink  req,
    cau_rsp_if.source rsp
);
    import cau_pkg::*;

    logic      valid_c [QBITS+1];
    logic      ready_c [QBITS+1];
    cau_lane_t lane_c  [QBITS+1];

    cau_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .lane_valid (valid_c[0]),
        .lane       (lane_c[0]),
        .lane_ready (ready_c[0])
    );

    for (genvar i = 0; i < QBITS; i++)
    begin : g_cell
        cau_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_c[i]),
            .in_lane   (lane_c[i]),
            .in_ready  (ready_c[i]),
            .out_valid (valid_c[i+1]),
            .out_lane  (lane_c[i+1]),
            .out_ready (ready_c[i+1])
        );
    end

    cau_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .lane_valid (valid_c[QBITS]),
        .lane       (lane_c[QBITS]),
        .lane_ready (ready_c[QBITS]),
        .rsp        (rsp)
    );

endmodule

// ===== rtl/core/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front
// Products, sums and divider setup: three pipeline stages.
// ----------------------------------------------------------------------------
module cau_front (
    input  logic               clk,
    input  logic               rst_n,
    cau_req_if.sink            req,
    output logic               lane_valid,
    output cau_pkg::cau_lane_t lane,
    input  logic               lane_ready
);
    import cau_pkg::*;

    logic                 v1_reg, v2_reg, v3_reg;
    logic                 rdy1, rdy2, rdy3;
    cau_op_t              op1_reg, op2_reg;
    logic signed [16:0]   sre1_reg, sim1_reg;
    logic signed [31:0]   p0_reg, p1_reg, p2_reg, p3_reg, pd0_reg, pd1_reg;
    logic signed [VW-1:0] vre2_reg, vim2_reg;
    logic [31:0]          d2_reg;
    cau_lane_t            lane_reg, lane_next;

    logic signed [16:0]   sre1_next, sim1_next;
    logic signed [VW-1:0] vre2_next, vim2_next;
    logic [31:0]          mag_re, mag_im;
    logic [RW-1:0]        x_re, x_im, dlim;
    logic signed [VW-1:0] nre, nim;

    assign rdy3      = !v3_reg || lane_ready;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign req.ready = rdy1;
    assign lane_valid = v3_reg;
    assign lane       = lane_reg;

    always_comb
    begin
        if (cau_op_t'(req.opcode) == OP_SUB)
        begin
            sre1_next = $signed({req.a_re[15], req.a_re}) - $signed({req.b_re[15], req.b_re});
            sim1_next = $signed({req.a_im[15], req.a_im}) - $signed({req.b_im[15], req.b_im});
        end
        else
        begin
            sre1_next = $signed({req.a_re[15], req.a_re}) + $signed({req.b_re[15], req.b_re});
            sim1_next = $signed({req.a_im[15], req.a_im}) + $signed({req.b_im[15], req.b_im});
        end
    end

    always_comb
    begin
        unique case (op1_reg)
            OP_MUL:
            begin
                vre2_next = VW'(p0_reg) - VW'(p1_reg);
                vim2_next = VW'(p2_reg) + VW'(p3_reg);
            end
            OP_DIV:
            begin
                vre2_next = VW'(p0_reg) + VW'(p1_reg);
                vim2_next = VW'(p3_reg) - VW'(p2_reg);
            end
            default:
            begin
                vre2_next = VW'(sre1_reg);
                vim2_next = VW'(sim1_reg);
            end
        endcase
    end

    always_comb
    begin
        nre       = -vre2_reg;
        nim       = -vim2_reg;
        mag_re    = vre2_reg[VW-1] ? nre[31:0] : vre2_reg[31:0];
        mag_im    = vim2_reg[VW-1] ? nim[31:0] : vim2_reg[31:0];
        x_re      = (RW'(mag_re) << 9) + RW'(d2_reg);
        x_im      = (RW'(mag_im) << 9) + RW'(d2_reg);
        dlim      = RW'(d2_reg) << (QBITS + 1);
        lane_next.op     = op2_reg;
        lane_next.dz     = (op2_reg == OP_DIV) && (d2_reg == 32'd0);
        lane_next.v_re   = vre2_reg;
        lane_next.v_im   = vim2_reg;
        lane_next.dsh    = RW'(d2_reg) << QBITS;
        lane_next.rem_re = x_re;
        lane_next.rem_im = x_im;
        lane_next.q_re   = '0;
        lane_next.q_im   = '0;
        lane_next.neg_re = vre2_reg[VW-1];
        lane_next.neg_im = vim2_reg[VW-1];
        lane_next.big_re = x_re >= dlim;
        lane_next.big_im = x_im >= dlim;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= req.valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            op1_reg  <= cau_op_t'(req.opcode);
            sre1_reg <= sre1_next;
            sim1_reg <= sim1_next;
            p0_reg   <= 32'(req.a_re) * 32'(req.b_re);
            p1_reg   <= 32'(req.a_im) * 32'(req.b_im);
            p2_reg   <= 32'(req.a_re) * 32'(req.b_im);
            p3_reg   <= 32'(req.a_im) * 32'(req.b_re);
            pd0_reg  <= 32'(req.b_re) * 32'(req.b_re);
            pd1_reg  <= 32'(req.b_im) * 32'(req.b_im);
        end
        if (rdy2)
        begin
            op2_reg  <= op1_reg;
            vre2_reg <= vre2_next;
            vim2_reg <= vim2_next;
            d2_reg   <= $unsigned(pd0_reg) + $unsigned(pd1_reg);
        end
        if (rdy3)
        begin
            lane_reg <= lane_next;
        end
    end

endmodule

// ===== rtl/core/cau_div_cell.sv =====
// ----------------------------------------------------------------------------
// cau_div_cell
// One restoring divide step for both result parts; one quotient bit each.
// ----------------------------------------------------------------------------
module cau_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  cau_pkg::cau_lane_t in_lane,
    output logic               in_ready,
    output logic               out_valid,
    output cau_pkg::cau_lane_t out_lane,
    input  logic               out_ready
);
    import cau_pkg::*;

    logic          valid_reg;
    cau_lane_t     lane_reg, lane_next;
    logic          ge_re, ge_im;
    logic [RW-1:0] r_re, r_im;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

    always_comb
    begin
        ge_re = in_lane.rem_re >= in_lane.dsh;
        ge_im = in_lane.rem_im >= in_lane.dsh;
        r_re  = ge_re ? in_lane.rem_re - in_lane.dsh : in_lane.rem_re;
        r_im  = ge_im ? in_lane.rem_im - in_lane.dsh : in_lane.rem_im;
        lane_next        = in_lane;
        lane_next.rem_re = {r_re[RW-2:0], 1'b0};
        lane_next.rem_im = {r_im[RW-2:0], 1'b0};
        lane_next.q_re   = {in_lane.q_re[QBITS-2:0], ge_re};
        lane_next.q_im   = {in_lane.q_im[QBITS-2:0], ge_im};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
            lane_reg <= lane_next;
    end

endmodule

// ===== rtl/core/cau_back.sv =====
// ----------------------------------------------------------------------------
// cau_back
// Rounding, saturation and flags; drives the result register.
// ----------------------------------------------------------------------------
module cau_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               lane_valid,
    input  cau_pkg::cau_lane_t lane,
    output logic               lane_ready,
    cau_rsp_if.source          rsp
);
    import cau_pkg::*;

    logic               valid_reg;
    logic signed [15:0] re_reg, im_reg;
    logic               dz_reg, ov_reg;
    logic [16:0]        fre, fim;

    function automatic logic [16:0] finish(
        input cau_op_t              op,
        input logic                 dz,
        input logic signed [VW-1:0] v,
        input logic [QBITS-1:0]     q,
        input logic                 neg,
        input logic                 big
    );
        logic [VW-1:0] mag;
        logic [VW-1:0] rq;
        logic          sat;
        logic [15:0]   val;
        mag = v[VW-1] ? VW'(-v) : VW'(v);
        rq  = (op == OP_MUL) ? ((mag + VW'(128)) >> 8) : mag;
        if (op == OP_DIV)
        begin
            if (dz)
            begin
                sat = 1'b0;
                val = '0;
            end
            else if (!neg)
            begin
                sat = big || (q > QBITS'(32767));
                val = sat ? 16'h7fff : q[15:0];
            end
            else
            begin
                sat = big || (q > QBITS'(32768));
                val = sat ? 16'h8000 : 16'(QBITS'(0) - q);
            end
        end
        else if (!v[VW-1])
        begin
            sat = rq > VW'(32767);
            val = sat ? 16'h7fff : rq[15:0];
        end
        else
        begin
            sat = rq > VW'(32768);
            val = sat ? 16'h8000 : 16'(VW'(0) - rq);
        end
        return {sat, val};
    endfunction

    assign fre = finish(lane.op, lane.dz, lane.v_re, lane.q_re, lane.neg_re, lane.big_re);
    assign fim = finish(lane.op, lane.dz, lane.v_im, lane.q_im, lane.neg_im, lane.big_im);

    assign lane_ready      = !valid_reg || rsp.ready;
    assign rsp.valid       = valid_reg;
    assign rsp.r_re        = re_reg;
    assign rsp.r_im        = im_reg;
    assign rsp.div_by_zero = dz_reg;
    assign rsp.overflow    = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (lane_ready)
            valid_reg <= lane_valid;
    end

    always_ff @(posedge clk)
    begin
        if (lane_ready)
        begin
            re_reg <= fre[15:0];
            im_reg <= fim[15:0];
            dz_reg <= lane.dz;
            ov_reg <= fre[16] | fim[16];
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the complex arithmetic unit. A table of directed operand
// sets runs first, then random ones; each result is checked in order against
// a table result or a bit-exact Q8.8 predictor; both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import cau_pkg::*;

    typedef struct {
        logic [1:0]         opcode;
        logic signed [15:0] a_re;
        logic signed [15:0] a_im;
        logic signed [15:0] b_re;
        logic signed [15:0] b_im;
    } operands_t;

    typedef struct {
        logic signed [15:0] r_re;
        logic signed [15:0] r_im;
        logic               dz;
        logic               ov;
    } cplx_result_t;

    typedef struct {
        operands_t    ops;
        bit           typed;
        cplx_result_t res;
    } stim_row_t;

    localparam int N_RANDOM    = 830;
    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    int   cycles = 0;
    int   errors = 0;
    bit   calm;

    cplx_result_t pending_results[$];
    stim_row_t    directed[$];

    cau_req_if req ();
    cau_rsp_if rsp ();

    complex_arithmetic_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint round_near(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic signed [15:0] saturate(longint v, ref logic ov);
        if (v > 32767)
        begin
            ov = 1'b1;
            return 16'sh7fff;
        end
        if (v < -32768)
        begin
            ov = 1'b1;
            return -16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic cplx_result_t complex_compute(operands_t o);
        cplx_result_t r;
        longint ar, ai, br, bi, re, im, d;
        logic ov;
        ar = o.a_re; ai = o.a_im; br = o.b_re; bi = o.b_im;
        re = 0; im = 0; ov = 1'b0;
        r.dz = 1'b0;
        case (cau_op_t'(o.opcode))
            OP_ADD:
            begin
                re = ar + br;
                im = ai + bi;
            end
            OP_SUB:
            begin
                re = ar - br;
                im = ai - bi;
            end
            OP_MUL:
            begin
                re = round_near(ar * br - ai * bi, 256);
                im = round_near(ar * bi + ai * br, 256);
            end
            default:
            begin
                d = br * br + bi * bi;
                if (d == 0)
                    r.dz = 1'b1;
                else
                begin
                    re = round_near((ar * br + ai * bi) * 256, d);
                    im = round_near((ai * br - ar * bi) * 256, d);
                end
            end
        endcase
        r.r_re = saturate(re, ov);
        r.r_im = saturate(im, ov);
        r.ov = ov;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return -16'sh8000;
            2: return 16'sh0000;
            3: return 16'(signed'($urandom_range(0, 1023)) - 512);
            4: return 16'(signed'($urandom_range(0, 255)) - 128);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic stim_row_t row(logic [1:0] op, int ar, int ai, int br, int bi,
                                      bit typed = 0, int rr = 0, int ri = 0,
                                      bit dz = 0, bit ov = 0);
        stim_row_t s;
        s.ops.opcode = op;
        s.ops.a_re = 16'(ar); s.ops.a_im = 16'(ai);
        s.ops.b_re = 16'(br); s.ops.b_im = 16'(bi);
        s.typed = typed;
        s.res.r_re = 16'(rr); s.res.r_im = 16'(ri); s.res.dz = dz; s.res.ov = ov;
        return s;
    endfunction

    task automatic send_transaction(stim_row_t s);
        req.valid  <= 1'b1;
        req.opcode <= s.ops.opcode;
        req.a_re   <= s.ops.a_re;
        req.a_im   <= s.ops.a_im;
        req.b_re   <= s.ops.b_re;
        req.b_im   <= s.ops.b_im;
        do @(posedge clk); while (!req.ready);
        pending_results.push_back(s.typed ? s.res : complex_compute(s.ops));
    endtask

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("complex_arithmetic_unit verification failed");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        cplx_result_t w;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected transaction", 1, 0);
            else
            begin
                w = pending_results.pop_front();
                if (rsp.r_re !== w.r_re) report_mismatch("r_re", rsp.r_re, w.r_re);
                if (rsp.r_im !== w.r_im) report_mismatch("r_im", rsp.r_im, w.r_im);
                if (rsp.div_by_zero !== w.dz)
                    report_mismatch("div_by_zero", rsp.div_by_zero, w.dz);
                if (rsp.overflow !== w.ov) report_mismatch("overflow", rsp.overflow, w.ov);
            end
        end
    end

    // result side stalls
    initial
    begin
        int n;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = $urandom_range(1, 20);
            rsp.ready <= 1'b1;
            repeat (n) @(posedge clk);
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial
    begin
        stim_row_t s;
        int timeout;
        calm = 0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.opcode = OP_ADD;
        req.a_re = '0; req.a_im = '0; req.b_re = '0; req.b_im = '0;

        directed.push_back(row(OP_ADD, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        directed.push_back(row(OP_ADD, 32767, 32767, 1, 1, 1, 32767, 32767, 0, 1));
        directed.push_back(row(OP_ADD, -32768, -32768, -1, -1, 1, -32768, -32768, 0, 1));
        directed.push_back(row(OP_ADD, 32767, -32768, -32768, 32767, 1, -1, -1, 0, 0));
        directed.push_back(row(OP_SUB, -32768, 0, 1, 0, 1, -32768, 0, 0, 1));
        directed.push_back(row(OP_SUB, 32767, 0, -32768, 0, 1, 32767, 0, 0, 1));
        directed.push_back(row(OP_SUB, 100, -200, 100, -200, 1, 0, 0, 0, 0));
        directed.push_back(row(OP_MUL, 256, 0, 256, 0, 1, 256, 0, 0, 0));
        directed.push_back(row(OP_MUL, 0, 256, 0, 256, 1, -256, 0, 0, 0));
        directed.push_back(row(OP_MUL, 32767, 32767, 32767, 32767, 1, 0, 32767, 0, 1));
        directed.push_back(row(OP_MUL, -32768, -32768, -32768, -32768, 1, 0, 32767, 0, 1));
        directed.push_back(row(OP_MUL, 1, 0, 128, 0));
        directed.push_back(row(OP_MUL, -1, 0, 128, 0));
        directed.push_back(row(OP_MUL, 3, 5, -7, 11));
        directed.push_back(row(OP_DIV, 1234, -567, 0, 0, 1, 0, 0, 1, 0));
        directed.push_back(row(OP_DIV, -32768, 32767, 0, 0, 1, 0, 0, 1, 0));
        directed.push_back(row(OP_DIV, 256, 0, 256, 0, 1, 256, 0, 0, 0));
        directed.push_back(row(OP_DIV, 32767, 32767, 1, 0, 1, 32767, 32767, 0, 1));
        directed.push_back(row(OP_DIV, -32768, -32768, 1, 1, 1, -32768, 0, 0, 1));
        directed.push_back(row(OP_DIV, 256, 256, 0, 256));
        directed.push_back(row(OP_DIV, 1, 0, -32768, -32768));
        directed.push_back(row(OP_DIV, 32767, -32768, 32767, -32768));
        directed.push_back(row(OP_DIV, 100, 0, 3, 0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_transaction(directed[i]);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            s.typed = 0;
            s.ops.opcode = 2'($urandom_range(0, 3));
            s.ops.a_re = pick_value();
            s.ops.a_im = pick_value();
            if (s.ops.opcode == OP_DIV && $urandom_range(0, 15) == 0)
            begin
                s.ops.b_re = '0;
                s.ops.b_im = '0;
            end
            else
            begin
                s.ops.b_re = pick_value();
                s.ops.b_im = pick_value();
            end
            if (i > N_RANDOM - 150)
                calm = 1;
            send_transaction(s);
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                req.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        req.valid <= 1'b0;

        timeout = 0;
        while (pending_results.size() != 0 && timeout < 5000)
        begin
            @(posedge clk);
            timeout++;
        end
        if (pending_results.size() != 0)
            report_mismatch("missing transactions", pending_results.size(), 0);
        repeat (30) @(posedge clk);

        if (errors == 0)
            $display("complex_arithmetic_unit verification clean");
        else
            $display("complex_arithmetic_unit verification failed");
        $finish;
    end
endmodule
